// ===== rtl/core/xsu_pkg.sv =====
// Shared types and codes for the cross-reference stream entry unpacker.
// Used by xsu_entry_core and xref_stream_entry_unpacker_top; no dependencies.
package xsu_pkg;

	localparam int OBJ_W     = 24;
	localparam int BASE_W    = 23;
	localparam int COUNT_W   = 24;
	localparam int FIELD_W   = 64;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the write port
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WIDTH = 2'd2;

	// Item kinds
	localparam logic MODE_SECTION = 1'b0;
	localparam logic MODE_DATA    = 1'b1;

	// Reset widths
	localparam logic [CFG_W-1:0] TYPE_WIDTH_RST   = 4'd1;
	localparam logic [CFG_W-1:0] FIRST_WIDTH_RST  = 4'd2;
	localparam logic [CFG_W-1:0] SECOND_WIDTH_RST = 4'd1;

	typedef struct packed {
		logic               mode;
		logic [BASE_W-1:0]  section_first;
		logic [COUNT_W-1:0] section_count;
		logic [7:0]         data_byte;
	} item_t;

	typedef struct packed {
		logic [OBJ_W-1:0]   object_number;
		logic [FIELD_W-1:0] entry_type;
		logic [FIELD_W-1:0] field_one;
		logic [FIELD_W-1:0] field_two;
		logic               section_last;
		logic               status;
	} result_t;

endpackage

// ===== rtl/core/xsu_entry_core.sv =====
// Entry assembly state: field widths, byte position, accumulators and section tracking.
// Depends on xsu_pkg. Consumes one item per fire and returns its result in the same cycle.
module xsu_entry_core #(
	parameter int MAX_FIELD_BYTES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [xsu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [xsu_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              fire,
	input  xsu_pkg::item_t                    item,
	output logic                              res_valid,
	output xsu_pkg::result_t                  res
);

	localparam int ACC_W = MAX_FIELD_BYTES * 8;
	localparam int POS_W = $clog2(3 * MAX_FIELD_BYTES + 1);
	localparam logic [xsu_pkg::CFG_W-1:0] MAX_W = xsu_pkg::CFG_W'(MAX_FIELD_BYTES);

	logic [xsu_pkg::CFG_W-1:0]   type_width_q, first_width_q, second_width_q;
	logic [POS_W-1:0]            pos_q;
	logic [ACC_W-1:0]            type_acc_q, first_acc_q, second_acc_q;
	logic [xsu_pkg::BASE_W-1:0]  base_q;
	logic [xsu_pkg::COUNT_W-1:0] remaining_q;
	logic [xsu_pkg::OBJ_W-1:0]   index_q;

	logic [POS_W-1:0] tw, fw, sw, bound_first, total, pos_next;
	logic [ACC_W-1:0] type_acc_d, first_acc_d, second_acc_d, byte_ext;
	logic             is_data, entry_done, section_open;

	always_comb begin
		tw = POS_W'((type_width_q   > MAX_W) ? MAX_W : type_width_q);
		fw = POS_W'((first_width_q  > MAX_W) ? MAX_W : first_width_q);
		sw = POS_W'((second_width_q > MAX_W) ? MAX_W : second_width_q);
		bound_first = tw + fw;
		total       = bound_first + sw;
		pos_next    = pos_q + POS_W'(1);
		byte_ext    = ACC_W'(item.data_byte);

		type_acc_d   = type_acc_q;
		first_acc_d  = first_acc_q;
		second_acc_d = second_acc_q;
		priority if (pos_q < tw) begin
			type_acc_d = (type_acc_q << 8) | byte_ext;
		end else if (pos_q < bound_first) begin
			first_acc_d = (first_acc_q << 8) | byte_ext;
		end else begin
			second_acc_d = (second_acc_q << 8) | byte_ext;
		end

		is_data      = (item.mode == xsu_pkg::MODE_DATA) && (total != '0);
		entry_done   = is_data && (pos_next == total);
		section_open = (remaining_q != '0);
		res_valid    = fire && entry_done;

		res.entry_type = xsu_pkg::FIELD_W'(type_acc_d);
		res.field_one  = xsu_pkg::FIELD_W'(first_acc_d);
		res.field_two  = xsu_pkg::FIELD_W'(second_acc_d);
		if (section_open) begin
			res.object_number = xsu_pkg::OBJ_W'({1'b0, base_q} + index_q);
			res.section_last  = (remaining_q == xsu_pkg::COUNT_W'(1));
			res.status        = 1'b0;
		end else begin
			res.object_number = '0;
			res.section_last  = 1'b0;
			res.status        = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_width_q   <= xsu_pkg::TYPE_WIDTH_RST;
			first_width_q  <= xsu_pkg::FIRST_WIDTH_RST;
			second_width_q <= xsu_pkg::SECOND_WIDTH_RST;
			pos_q          <= '0;
			type_acc_q     <= '0;
			first_acc_q    <= '0;
			second_acc_q   <= '0;
			base_q         <= '0;
			remaining_q    <= '0;
			index_q        <= '0;
		end else if (cfg_we) begin
			// a width change drops any partial entry
			unique case (cfg_index)
				xsu_pkg::CFG_TYPE_WIDTH: begin
					type_width_q <= cfg_data;
					pos_q <= '0;
					type_acc_q <= '0; first_acc_q <= '0; second_acc_q <= '0;
				end
				xsu_pkg::CFG_FIRST_WIDTH: begin
					first_width_q <= cfg_data;
					pos_q <= '0;
					type_acc_q <= '0; first_acc_q <= '0; second_acc_q <= '0;
				end
				xsu_pkg::CFG_SECOND_WIDTH: begin
					second_width_q <= cfg_data;
					pos_q <= '0;
					type_acc_q <= '0; first_acc_q <= '0; second_acc_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (fire) begin
			if (item.mode == xsu_pkg::MODE_SECTION) begin
				pos_q        <= '0;
				type_acc_q   <= '0;
				first_acc_q  <= '0;
				second_acc_q <= '0;
				base_q       <= item.section_first;
				remaining_q  <= item.section_count;
				index_q      <= '0;
			end else if (entry_done) begin
				pos_q        <= '0;
				type_acc_q   <= '0;
				first_acc_q  <= '0;
				second_acc_q <= '0;
				if (section_open) begin
					index_q     <= index_q + xsu_pkg::OBJ_W'(1);
					remaining_q <= remaining_q - xsu_pkg::COUNT_W'(1);
				end
			end else if (is_data) begin
				pos_q        <= pos_next;
				type_acc_q   <= type_acc_d;
				first_acc_q  <= first_acc_d;
				second_acc_q <= second_acc_d;
			end
		end
	end

endmodule

// ===== rtl/core/xref_stream_entry_unpacker_top.sv =====
// Top level of the cross-reference stream entry unpacker.
// Depends on xsu_pkg and xsu_entry_core; holds the input stage and the output skid pair.
//
// Usage:
//   The host writes the three field widths (bytes, 0..8, larger values act as 8) on
//   the cfg port while no item is in flight; each write drops a partial entry.
//   Input items arrive on in_valid/in_stall: mode 0 opens a section with its first
//   object number and entry count, mode 1 carries one decoded stream byte.
//   When the last byte of an entry arrives, one result leaves on out_valid/out_stall
//   with the object number, the three field values, the section-last mark and a
//   status bit that flags an entry outside any open section.
//   A result passes through the input register, then the output register, waiting
//   in the skid register first while the receiver stalls.
//   Throughput: one item per cycle while in_stall is low; each byte is a shift-add
//   and counter update in the entry core between the input and output registers.
//   A stalled receiver first fills the skid register; in_stall rises only when
//   both output registers hold results and the input stage is occupied.
//   Reset restores widths 1/2/1, closes the section and clears all partial state.
module xref_stream_entry_unpacker_top #(
	parameter int MAX_FIELD_BYTES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [xsu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [xsu_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic [xsu_pkg::BASE_W-1:0]      section_first,
	input  logic [xsu_pkg::COUNT_W-1:0]     section_count,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [xsu_pkg::OBJ_W-1:0]       object_number,
	output logic [xsu_pkg::FIELD_W-1:0]     entry_type,
	output logic [xsu_pkg::FIELD_W-1:0]     field_one,
	output logic [xsu_pkg::FIELD_W-1:0]     field_two,
	output logic                            section_last,
	output logic                            status
);

	logic             valid_s1;
	xsu_pkg::item_t   item_s1;
	logic             fire_s1;
	logic             res_valid;
	xsu_pkg::result_t res;
	logic             out_valid_q, skid_valid_q;
	xsu_pkg::result_t out_q, skid_q;
	logic             out_take;

	assign fire_s1  = valid_s1 && !skid_valid_q;
	assign in_stall = valid_s1 && skid_valid_q;
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.mode          <= mode;
			item_s1.section_first <= section_first;
			item_s1.section_count <= section_count;
			item_s1.data_byte     <= data_byte;
		end
	end

	xsu_entry_core #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire_s1),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// out register plus skid; a push only happens while the skid is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign object_number = out_q.object_number;
	assign entry_type    = out_q.entry_type;
	assign field_one     = out_q.field_one;
	assign field_two     = out_q.field_two;
	assign section_last  = out_q.section_last;
	assign status        = out_q.status;

	// skid never holds a result behind an empty output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while output register is empty");

	// the core only produces a result while the skid has room
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !skid_valid_q)
		else $error("result produced with skid full");

	// a section item never yields a result
	a_section_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.mode == xsu_pkg::MODE_SECTION |-> !res_valid)
		else $error("section item produced a result");

	// flagged entries carry no object number and no section mark
	a_flag_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status |-> res.object_number == '0 && !res.section_last)
		else $error("flagged entry carries section data");

	// a held result with a full skid must stall the input once it is occupied
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && skid_valid_q |-> in_stall)
		else $error("input not stalled with both output registers full");

endmodule

// ===== tb/sv/xref_stream_entry_unpacker_top_test.sv =====
// Self-checking testbench for xref_stream_entry_unpacker_top.
// Depends on xsu_pkg and the RTL; predicts every entry in step with the accepted items.
// Covers directed corner cases, then random section streams under several width settings.
module xref_stream_entry_unpacker_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BYTES     = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int MAX_CYCLES    = 200000;
	localparam logic [xsu_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
	localparam logic [xsu_pkg::COUNT_W-1:0]   MAX_COUNT        = 24'd8388608;
	localparam logic [xsu_pkg::BASE_W-1:0]    MAX_FIRST        = 23'd8388607;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [xsu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [xsu_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          mode = xsu_pkg::MODE_SECTION;
	logic [xsu_pkg::BASE_W-1:0]    section_first = '0;
	logic [xsu_pkg::COUNT_W-1:0]   section_count = '0;
	logic [7:0]                    data_byte = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [xsu_pkg::OBJ_W-1:0]     object_number;
	logic [xsu_pkg::FIELD_W-1:0]   entry_type;
	logic [xsu_pkg::FIELD_W-1:0]   field_one;
	logic [xsu_pkg::FIELD_W-1:0]   field_two;
	logic                          section_last;
	logic                          status;

	xref_stream_entry_unpacker_top #(.MAX_FIELD_BYTES(MAX_BYTES)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .section_first(section_first),
		.section_count(section_count), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.object_number(object_number), .entry_type(entry_type),
		.field_one(field_one), .field_two(field_two),
		.section_last(section_last), .status(status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Unpacker state as predicted from accepted items and register writes
	logic [xsu_pkg::CFG_W-1:0]   w_type, w_first, w_second;
	logic [4:0]                  pos;
	logic [xsu_pkg::FIELD_W-1:0] acc_type, acc_first, acc_second;
	logic [xsu_pkg::BASE_W-1:0]  sec_base;
	logic [xsu_pkg::COUNT_W-1:0] sec_left;
	logic [xsu_pkg::COUNT_W-1:0] sec_index;

	xsu_pkg::item_t   pending_items[$];
	xsu_pkg::result_t expected_entries[$];
	xsu_pkg::item_t   next_item;
	xsu_pkg::result_t want_entry;

	bit in_taken = 1'b0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_pct = 0;
	int pattern_left = 0;
	int hold_count = 0;
	bit long_hold_go = 1'b0;
	bit long_hold_done = 1'b0;
	int cycle_count = 0;
	int mismatches = 0;
	int items_sent = 0;
	int entries_seen = 0;
	int flagged_seen = 0;
	int settings_used = 1;

	function automatic int unsigned clamp_bytes(input logic [xsu_pkg::CFG_W-1:0] w);
		return (w > MAX_BYTES) ? MAX_BYTES : int'(w);
	endfunction

	function automatic int unsigned entry_bytes();
		return clamp_bytes(w_type) + clamp_bytes(w_first) + clamp_bytes(w_second);
	endfunction

	function automatic void drop_partial();
		pos = '0;
		acc_type = '0;
		acc_first = '0;
		acc_second = '0;
	endfunction

	function automatic void reset_unpacker();
		w_type = xsu_pkg::TYPE_WIDTH_RST;
		w_first = xsu_pkg::FIRST_WIDTH_RST;
		w_second = xsu_pkg::SECOND_WIDTH_RST;
		drop_partial();
		sec_base = '0;
		sec_left = '0;
		sec_index = '0;
	endfunction

	function automatic void load_width(input logic [xsu_pkg::CFG_IDX_W-1:0] idx,
			input logic [xsu_pkg::CFG_W-1:0] val);
		if (idx == xsu_pkg::CFG_TYPE_WIDTH) begin
			w_type = val;
		end else if (idx == xsu_pkg::CFG_FIRST_WIDTH) begin
			w_first = val;
		end else if (idx == xsu_pkg::CFG_SECOND_WIDTH) begin
			w_second = val;
		end else begin
			return;
		end
		drop_partial();
	endfunction

	function automatic void absorb_item(input logic m,
			input logic [xsu_pkg::BASE_W-1:0] first,
			input logic [xsu_pkg::COUNT_W-1:0] count, input logic [7:0] b);
		int unsigned tw, fw, total;
		xsu_pkg::result_t r;
		tw = clamp_bytes(w_type);
		fw = clamp_bytes(w_first);
		total = entry_bytes();
		if (m == xsu_pkg::MODE_SECTION) begin
			drop_partial();
			sec_base = first;
			sec_left = count;
			sec_index = '0;
			return;
		end
		if (total == 0)
			return;
		if (pos < tw)
			acc_type = {acc_type[xsu_pkg::FIELD_W-9:0], b};
		else if (pos < tw + fw)
			acc_first = {acc_first[xsu_pkg::FIELD_W-9:0], b};
		else
			acc_second = {acc_second[xsu_pkg::FIELD_W-9:0], b};
		pos = pos + 5'd1;
		if (pos < total)
			return;
		r.entry_type = acc_type;
		r.field_one = acc_first;
		r.field_two = acc_second;
		if (sec_left != 0) begin
			r.object_number = {1'b0, sec_base} + sec_index;
			sec_index = sec_index + 1'b1;
			sec_left = sec_left - 1'b1;
			r.section_last = (sec_left == 0);
			r.status = 1'b0;
		end else begin
			r.object_number = '0;
			r.section_last = 1'b0;
			r.status = 1'b1;
		end
		expected_entries.push_back(r);
		drop_partial();
	endfunction

	// Prediction follows exactly what the block accepts at each rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				load_width(cfg_index, cfg_data);
			in_taken = in_valid && !in_stall;
			if (in_taken) begin
				absorb_item(mode, section_first, section_count, data_byte);
				items_sent++;
			end
		end else begin
			in_taken = 1'b0;
		end
	end

	// Sender: bursts of random length with random gaps, payload held while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				next_item = pending_items.pop_front();
				mode <= next_item.mode;
				section_first <= next_item.section_first;
				section_count <= next_item.section_count;
				data_byte <= next_item.data_byte;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern of its own, plus one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (long_hold_go && !long_hold_done) begin
			out_stall <= 1'b1;
			hold_count++;
			if (hold_count == LONG_HOLD)
				long_hold_done = 1'b1;
		end else begin
			if (pattern_left == 0) begin
				case ($urandom_range(4))
					0, 1: stall_pct = 0;
					2: stall_pct = 25;
					3: stall_pct = 50;
					default: stall_pct = 85;
				endcase
				pattern_left = $urandom_range(10, 80);
			end
			pattern_left--;
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic check_field(input string name, input logic [xsu_pkg::FIELD_W-1:0] want,
			input logic [xsu_pkg::FIELD_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Monitor and run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("%0t: no progress after %0d cycles", $time, MAX_CYCLES);
			$display("status: fail");
			$finish;
		end else if (arst_n && out_valid && !out_stall) begin
			if (expected_entries.size() == 0) begin
				$display("%0t: unexpected entry, expected none, actual object %0h type %0h",
					$time, object_number, entry_type);
				mismatches++;
			end else begin
				want_entry = expected_entries.pop_front();
				check_field("object_number", xsu_pkg::FIELD_W'(want_entry.object_number),
					xsu_pkg::FIELD_W'(object_number));
				check_field("entry_type", want_entry.entry_type, entry_type);
				check_field("field_one", want_entry.field_one, field_one);
				check_field("field_two", want_entry.field_two, field_two);
				check_field("section_last", xsu_pkg::FIELD_W'(want_entry.section_last),
					xsu_pkg::FIELD_W'(section_last));
				check_field("status", xsu_pkg::FIELD_W'(want_entry.status),
					xsu_pkg::FIELD_W'(status));
				entries_seen++;
				if (want_entry.status)
					flagged_seen++;
			end
		end
	end

	function automatic void push_section(input logic [xsu_pkg::BASE_W-1:0] first,
			input logic [xsu_pkg::COUNT_W-1:0] count);
		xsu_pkg::item_t it;
		it.mode = xsu_pkg::MODE_SECTION;
		it.section_first = first;
		it.section_count = count;
		it.data_byte = 8'($urandom_range(255));
		pending_items.push_back(it);
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		xsu_pkg::item_t it;
		it.mode = xsu_pkg::MODE_DATA;
		it.section_first = xsu_pkg::BASE_W'($urandom_range(0, MAX_FIRST));
		it.section_count = xsu_pkg::COUNT_W'($urandom_range(0, MAX_COUNT));
		it.data_byte = b;
		pending_items.push_back(it);
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [xsu_pkg::BASE_W-1:0] rand_first();
		if ($urandom_range(3) == 0)
			return xsu_pkg::BASE_W'($urandom_range(MAX_FIRST - 8, MAX_FIRST));
		return xsu_pkg::BASE_W'($urandom_range(0, MAX_FIRST));
	endfunction

	function automatic void push_bytes(input int n);
		for (int i = 0; i < n; i++)
			push_byte(rand_byte());
	endfunction

	// Mostly well-formed sections; else overruns, empty or open sections, partial entries
	function automatic void queue_stream(input int budget);
		int made, eb, cnt, extra;
		made = 0;
		eb = int'(entry_bytes());
		while (made < budget) begin
			if (eb == 0) begin
				if ($urandom_range(9) == 0)
					push_section(rand_first(), xsu_pkg::COUNT_W'($urandom_range(0, 5)));
				else
					push_byte(rand_byte());
				made++;
				continue;
			end
			cnt = $urandom_range(1, 5);
			extra = (eb > 1) ? $urandom_range(1, eb - 1) : 0;
			case ($urandom_range(9))
				6: begin
					// overrun: one entry past the section, then a leftover partial
					push_section(rand_first(), xsu_pkg::COUNT_W'(cnt));
					push_bytes(cnt * eb + eb + extra);
					made += 1 + cnt * eb + eb + extra;
				end
				7: begin
					push_section(rand_first(), '0);
					push_bytes(eb);
					made += 1 + eb;
				end
				8: begin
					push_bytes(extra);
					made += extra;
				end
				9: begin
					push_section(rand_first(),
						xsu_pkg::COUNT_W'($urandom_range(1, MAX_COUNT)));
					push_bytes(cnt * eb);
					made += 1 + cnt * eb;
				end
				default: begin
					push_section(rand_first(), xsu_pkg::COUNT_W'(cnt));
					push_bytes(cnt * eb);
					made += 1 + cnt * eb;
				end
			endcase
		end
	endfunction

	task automatic settle();
		int quiet;
		quiet = 0;
		while (quiet < SETTLE_CYCLES) begin
			@(posedge clk);
			if (pending_items.size() == 0 && !in_valid && expected_entries.size() == 0)
				quiet++;
			else
				quiet = 0;
		end
	endtask

	task automatic program_widths(input logic [xsu_pkg::CFG_W-1:0] tw,
			input logic [xsu_pkg::CFG_W-1:0] fw, input logic [xsu_pkg::CFG_W-1:0] sw);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= xsu_pkg::CFG_TYPE_WIDTH;
		cfg_data <= tw;
		@(negedge clk);
		cfg_index <= xsu_pkg::CFG_FIRST_WIDTH;
		cfg_data <= fw;
		@(negedge clk);
		cfg_index <= xsu_pkg::CFG_SECOND_WIDTH;
		cfg_data <= sw;
		// an unused index must leave widths and the partial entry alone
		@(negedge clk);
		cfg_index <= CFG_UNUSED_INDEX;
		cfg_data <= xsu_pkg::CFG_W'($urandom_range(15));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [xsu_pkg::CFG_W-1:0] tw,
			input logic [xsu_pkg::CFG_W-1:0] fw, input logic [xsu_pkg::CFG_W-1:0] sw,
			input int budget);
		program_widths(tw, fw, sw);
		settings_used++;
		queue_stream(budget);
		settle();
	endtask

	initial begin
		reset_unpacker();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at reset widths 1/2/1
		push_bytes(0);
		push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF); push_byte(8'h00);
		push_section(MAX_FIRST, 24'd2);
		push_byte(8'h00); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
		push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
		push_section('0, MAX_COUNT);
		push_byte(8'h12); push_byte(8'h34);
		push_section(23'd5, '0);
		push_byte(8'hA5); push_byte(8'h5A); push_byte(8'hC3); push_byte(8'h3C);
		// leave a partial entry for the next register write to drop
		push_section(23'h2AAAAA, 24'h555555);
		push_byte(8'h01); push_byte(8'h80); push_byte(8'h7F);
		settle();

		run_phase(4'd1, 4'd2, 4'd1, 120);
		long_hold_go = 1'b1;
		run_phase(4'd1, 4'd0, 4'd0, 120);
		run_phase(4'd8, 4'd8, 4'd8, 100);
		run_phase(4'd0, 4'd0, 4'd0, 30);
		run_phase(4'd15, 4'd9, 4'd12, 70);
		run_phase(4'd0, 4'd3, 4'd2, 80);
		run_phase(4'd2, 4'd1, 4'd0, 80);
		run_phase(xsu_pkg::CFG_W'($urandom_range(15)), xsu_pkg::CFG_W'($urandom_range(15)),
			xsu_pkg::CFG_W'($urandom_range(1, 8)), 60);
		run_phase(xsu_pkg::CFG_W'($urandom_range(8)), xsu_pkg::CFG_W'($urandom_range(8)),
			xsu_pkg::CFG_W'($urandom_range(8)), 60);
		run_phase(4'd0, 4'd0, 4'd1, 50);

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d items and %0d entries (%0d outside a section)",
			items_sent, entries_seen, flagged_seen);
		$display("over %0d width settings, with %0d mismatches", settings_used, mismatches);
		if (mismatches == 0 && expected_entries.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
